>>> rtl/core/kjas_pkg.sv
// Package for the keyframe joint angle stepper: widths, angle constants,
// keyframe record, command codes and FIFO control/status structs.
// No dependencies.
package kjas_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_W     = 2;
  localparam int TGT_IN_W  = 27;
  localparam int TGT_W     = 28;
  localparam int STEPS_W   = 16;
  localparam int ANG_W     = 25;
  localparam int STEP_W    = 28;
  localparam int SUM_W     = 29;
  localparam int MAG_W     = 28;
  localparam int DIV_CNT_W = $clog2(MAG_W);

  localparam int FULL_TURN  = 360 * 65536;
  localparam int HALF_LIMIT = 185 * 65536;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_FREEZE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic signed [TGT_W-1:0] target;
    logic [STEPS_W-1:0]      remaining;
    logic [STEPS_W-1:0]      reload;
    logic                    loop_back;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

>>> rtl/core/keyframe_joint_angle_stepper.sv
// Keyframe joint angle stepper, top level. Uses kjas_pkg, kjas_fifo, kjas_divider.
// Add, freeze and unused commands: result strobed in the cycle after the start beat.
// Tick: fetch (load a keyframe or drop a zero-step one), adjust, divide, apply, wrap,
//   finish; with nothing to step it strobes from fetch. busy drops as the result
//   strobes, which cannot stall.
// Synchronous active-low reset: angle 0, no active keyframe, queue empty.
module keyframe_joint_angle_stepper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [kjas_pkg::CMD_W-1:0]          in_command,
  input  logic signed [kjas_pkg::TGT_IN_W-1:0] in_target_angle,
  input  logic [kjas_pkg::STEPS_W-1:0]        in_step_count,
  input  logic [kjas_pkg::STEPS_W-1:0]        in_reload_count,
  input  logic                                in_loop_back,
  output logic                                out_strobe,
  output logic [kjas_pkg::ANG_W-1:0]          out_joint_angle,
  output logic signed [kjas_pkg::STEP_W-1:0]  out_step_angle,
  output logic                                out_stepped,
  output logic                                out_queue_dropped
);
  import kjas_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_FETCH    = 9'b000000010,
    ST_LOAD     = 9'b000000100,
    ST_ADJ      = 9'b000001000,
    ST_DIV_GO   = 9'b000010000,
    ST_DIV_WAIT = 9'b000100000,
    ST_APPLY    = 9'b001000000,
    ST_WRAP     = 9'b010000000,
    ST_FIN      = 9'b100000000
  } state_t;

  localparam logic signed [SUM_W-1:0] FULL_S     = SUM_W'(FULL_TURN);
  localparam logic signed [SUM_W-1:0] HALF_S     = SUM_W'(HALF_LIMIT);
  localparam logic signed [SUM_W-1:0] NEG_HALF_S = -SUM_W'(HALF_LIMIT);
  localparam logic signed [TGT_W-1:0] FULL_T     = TGT_W'(FULL_TURN);

  state_t                    state_r, state_nxt;
  logic [ANG_W-1:0]          cur_r, cur_nxt;
  frame_t                    act_r, act_nxt;
  logic                      act_valid_r, act_valid_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [STEP_W-1:0]  step_r, step_nxt;
  logic                      strobe_r, strobe_nxt;
  logic signed [STEP_W-1:0]  out_step_r, out_step_nxt;
  logic                      out_stepped_r, out_stepped_nxt;
  logic                      out_drop_r, out_drop_nxt;

  fifo_ctl_t                 fifo_ctl;
  fifo_sts_t                 fifo_sts;
  frame_t                    push_data;
  frame_t                    fifo_rd;

  logic                      div_start;
  logic [MAG_W-1:0]          div_dividend;
  logic                      div_done;
  logic [MAG_W-1:0]          div_quo;

  logic signed [SUM_W-1:0]   cur_ext;
  logic signed [SUM_W-1:0]   diff_w;
  logic signed [SUM_W-1:0]   diff_abs;
  logic signed [STEP_W-1:0]  step_w;

  assign cur_ext  = $signed({{(SUM_W-ANG_W){1'b0}}, cur_r});
  assign diff_w   = SUM_W'(act_r.target) - cur_ext;
  assign diff_abs = diff_w[SUM_W-1] ? -diff_w : diff_w;
  assign step_w   = neg_r ? -$signed(div_quo) : $signed(div_quo);

  kjas_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fifo_ctl),
    .wr_data (push_data),
    .rd_data (fifo_rd),
    .sts     (fifo_sts)
  );

  kjas_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (act_r.remaining),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    act_nxt         = act_r;
    act_valid_nxt   = act_valid_r;
    sum_nxt         = sum_r;
    neg_nxt         = neg_r;
    step_nxt        = step_r;
    strobe_nxt      = 1'b0;
    out_step_nxt    = out_step_r;
    out_stepped_nxt = out_stepped_r;
    out_drop_nxt    = out_drop_r;
    fifo_ctl        = '0;
    div_start       = 1'b0;
    div_dividend    = diff_abs[MAG_W-1:0];
    push_data.target    = TGT_W'(in_target_angle);
    push_data.remaining = in_step_count;
    push_data.reload    = in_reload_count;
    push_data.loop_back = in_loop_back;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_step_nxt    = '0;
          out_stepped_nxt = 1'b0;
          out_drop_nxt    = 1'b0;
          strobe_nxt      = 1'b1;
          case (in_command)
            CMD_TICK: begin
              strobe_nxt = 1'b0;
              state_nxt  = ST_FETCH;
            end
            CMD_ADD: begin
              fifo_ctl.push = 1'b1;
              out_drop_nxt  = fifo_sts.full;
            end
            CMD_FREEZE: begin
              fifo_ctl.clear = 1'b1;
              act_valid_nxt  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (!act_valid_r) begin
          if (fifo_sts.empty) begin
            strobe_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            fifo_ctl.pop = 1'b1;
            state_nxt    = ST_LOAD;
          end
        end else if (act_r.remaining == '0) begin
          act_valid_nxt = 1'b0;
        end else begin
          state_nxt = ST_ADJ;
        end
      end
      ST_LOAD: begin
        act_nxt       = fifo_rd;
        act_valid_nxt = 1'b1;
        state_nxt     = ST_FETCH;
      end
      ST_ADJ: begin
        if (diff_w > HALF_S) begin
          act_nxt.target = act_r.target - FULL_T;
        end else if (diff_w < NEG_HALF_S) begin
          act_nxt.target = act_r.target + FULL_T;
        end
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        neg_nxt   = diff_w[SUM_W-1];
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        step_nxt  = step_w;
        sum_nxt   = cur_ext + SUM_W'(step_w);
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        if (sum_r[SUM_W-1]) begin
          sum_nxt = sum_r + FULL_S;
        end else if (sum_r > FULL_S) begin
          sum_nxt = sum_r - FULL_S;
        end else begin
          cur_nxt   = sum_r[ANG_W-1:0];
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        act_nxt.remaining = act_r.remaining - 1'b1;
        if (act_r.remaining == STEPS_W'(1)) begin
          act_valid_nxt = 1'b0;
          if (act_r.loop_back) begin
            fifo_ctl.push       = 1'b1;
            push_data.target    = act_r.target;
            push_data.remaining = act_r.reload;
            push_data.reload    = act_r.reload;
            push_data.loop_back = act_r.loop_back;
          end
        end
        out_step_nxt    = step_r;
        out_stepped_nxt = 1'b1;
        out_drop_nxt    = 1'b0;
        strobe_nxt      = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      act_valid_r <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      act_valid_r <= act_valid_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    sum_r         <= sum_nxt;
    neg_r         <= neg_nxt;
    step_r        <= step_nxt;
    out_step_r    <= out_step_nxt;
    out_stepped_r <= out_stepped_nxt;
    out_drop_r    <= out_drop_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = strobe_r;
  assign out_joint_angle   = cur_r;
  assign out_step_angle    = out_step_r;
  assign out_stepped       = out_stepped_r;
  assign out_queue_dropped = out_drop_r;

`ifndef SYNTHESIS
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_TICK) |=> busy)
    else $error("stepper: tick beat did not raise busy");
  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_GO) |-> (act_valid_r && act_r.remaining != '0))
    else $error("stepper: divide started without a live keyframe");
  a_fin_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (!sum_r[SUM_W-1] && sum_r <= FULL_S))
    else $error("stepper: angle not wrapped at finish");
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_joint_angle <= ANG_W'(FULL_TURN)))
    else $error("stepper: reported angle beyond full turn");
`endif

endmodule

>>> rtl/core/kjas_fifo.sv
// Keyframe FIFO: circular buffer in a memory array with registered read.
// Depends on kjas_pkg.
module kjas_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  kjas_pkg::fifo_ctl_t ctl,
  input  kjas_pkg::frame_t    wr_data,
  output kjas_pkg::frame_t    rd_data,
  output kjas_pkg::fifo_sts_t sts
);
  import kjas_pkg::*;

  frame_t              mem [QUEUE_DEPTH];
  frame_t              rd_data_r;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push_ok;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CNT_FULL);
  assign push_ok   = ctl.push && !sts.full;
  assign rd_data   = rd_data_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (push_ok) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop && !sts.empty) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok && !ctl.clear) begin
      mem[tail_r] <= wr_data;
    end
    if (ctl.pop) begin
      rd_data_r <= mem[head_r];
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !sts.empty)
    else $error("kjas_fifo: pop from empty queue");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("kjas_fifo: empty queue with unequal pointers");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && sts.full && !ctl.pop && !ctl.clear) |=> $stable(count_r))
    else $error("kjas_fifo: push into full queue changed count");
`endif

endmodule

>>> rtl/core/kjas_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, MAG_W quotient bits.
// Depends on kjas_pkg.
module kjas_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [kjas_pkg::MAG_W-1:0]        dividend,
  input  logic [kjas_pkg::STEPS_W-1:0]      divisor,
  output logic                              done,
  output logic [kjas_pkg::MAG_W-1:0]        quotient
);
  import kjas_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MAG_W-1:0]       dvd_r, dvd_nxt;
  logic [MAG_W-1:0]       quo_r, quo_nxt;
  logic [STEPS_W-1:0]     rem_r, rem_nxt;
  logic [STEPS_W-1:0]     dsr_r, dsr_nxt;
  logic [STEPS_W:0]       trial;
  logic [STEPS_W:0]       diff;
  logic                   qbit;

  assign trial    = {rem_r, dvd_r[MAG_W-1]};
  assign diff     = trial - {1'b0, dsr_r};
  assign qbit     = (trial >= {1'b0, dsr_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(MAG_W - 1);
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[MAG_W-2:0], 1'b0};
      quo_nxt = {quo_r[MAG_W-2:0], qbit};
      rem_nxt = qbit ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule
